/* rtl/core/cssd_pkg.sv */
package cssd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HDR_W      = 64;
  localparam int unsigned RANK_W     = 10;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // Value of paddr[2] that selects the own-rank register; paddr[2] selects the register slot.
  localparam logic REG_OWN_RANK = 1'b0;

  // Queue between the byte assembler and the record decoder.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHANNEL,
    PH_SKIP,
    PH_SOURCE,
    PH_DEST
  } phase_t;

  typedef enum logic [2:0] {
    RK_RESOURCE = 3'd0,
    RK_CHANNEL  = 3'd1,
    RK_TRANSFER = 3'd2,
    RK_SOURCE   = 3'd3,
    RK_DEST     = 3'd4
  } rec_kind_t;

  typedef enum logic [4:0] {
    OP_RESOURCE = 5'd0,
    OP_SYNC_A   = 5'd1,
    OP_SYNC_B   = 5'd2
  } opcode_t;

  // A completed word as classified by the front end.
  typedef struct packed {
    rec_kind_t          kind;
    logic [HDR_W-1:0]   word;
  } q_entry_t;

  typedef struct packed {
    logic [2:0]        record_kind;
    logic [4:0]        opcode;
    logic [4:0]        thread_value;
    logic [4:0]        notify_main;
    logic [4:0]        notify_per_thread;
    logic [4:0]        layer;
    logic [RANK_W-1:0] peer_rank;
    logic [2:0]        link_protocol;
    logic [9:0]        slice_value;
    logic [1:0]        two_bit_code;
    logic [3:0]        input_type;
    logic [3:0]        output_type;
  } result_t;

endpackage

/* rtl/core/cssd_in_if.sv */
interface cssd_in_if;
  import cssd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);

endinterface

/* rtl/core/cssd_out_if.sv */
interface cssd_out_if;
  import cssd_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        record_kind;
  logic [4:0]        opcode;
  logic [4:0]        thread_value;
  logic [4:0]        notify_main;
  logic [4:0]        notify_per_thread;
  logic [4:0]        layer;
  logic [RANK_W-1:0] peer_rank;
  logic [2:0]        link_protocol;
  logic [9:0]        slice_value;
  logic [1:0]        two_bit_code;
  logic [3:0]        input_type;
  logic [3:0]        output_type;

  modport source (
    output valid, output record_kind, output opcode, output thread_value,
    output notify_main, output notify_per_thread, output layer, output peer_rank,
    output link_protocol, output slice_value, output two_bit_code,
    output input_type, output output_type, input ready
  );
  modport sink (
    input valid, input record_kind, input opcode, input thread_value,
    input notify_main, input notify_per_thread, input layer, input peer_rank,
    input link_protocol, input slice_value, input two_bit_code,
    input input_type, input output_type, output ready
  );

endinterface

/* rtl/core/cssd_queue.sv */
module cssd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cssd_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output cssd_pkg::q_entry_t head
);
  import cssd_pkg::*;

  q_entry_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

/* rtl/core/cssd_front.sv */
module cssd_front (
  input  logic               clk,
  input  logic               rst_n,
  cssd_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               q_push,
  output cssd_pkg::q_entry_t q_data
);
  import cssd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [HDR_W-1:0]   word_r, word_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [7:0]         remain_r, remain_nxt;
  logic [3:0]         pend_r, pend_nxt;

  logic               accept;
  logic [HDR_W-1:0]   word_full;
  logic [2:0]         last_pos;
  logic               word_done;
  logic [7:0]         remain_dec;
  logic [4:0]         op;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    // The buffer is zero above the current byte, so writing the lane is the same as OR-ing it in.
    word_full = word_r;
    word_full[{pos_r, 3'b000} +: BYTE_W] = in_ch.file_byte;
    last_pos   = (phase_r == PH_HEADER) ? 3'd7 : 3'd3;
    word_done  = (pos_r == last_pos);
    remain_dec = remain_r - 8'd1;
    op         = word_full[4:0];
  end

  always_comb begin
    phase_nxt   = phase_r;
    word_nxt    = word_r;
    pos_nxt     = pos_r;
    remain_nxt  = remain_r;
    pend_nxt    = pend_r;
    q_push      = 1'b0;
    q_data.word = word_full;
    q_data.kind = RK_CHANNEL;

    if (accept) begin
      if (phase_r == PH_SKIP) begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt = PH_HEADER;
          pend_nxt  = '0;
        end
      end else if (!word_done) begin
        word_nxt = word_full;
        pos_nxt  = pos_r + 3'd1;
      end else begin
        word_nxt = '0;
        pos_nxt  = '0;
        unique case (phase_r)
          PH_HEADER: begin
            if (op == OP_RESOURCE) begin
              q_push      = 1'b1;
              q_data.kind = RK_RESOURCE;
              remain_nxt  = word_full[29:22];
              phase_nxt   = (word_full[29:22] != '0) ? PH_CHANNEL : PH_HEADER;
            end else if (op == OP_SYNC_A || op == OP_SYNC_B) begin
              remain_nxt = {3'b000, word_full[14:10]};
              phase_nxt  = (word_full[14:10] != '0) ? PH_SKIP : PH_HEADER;
            end else begin
              q_push      = 1'b1;
              q_data.kind = RK_TRANSFER;
              if (word_full[23:20] != '0) begin
                phase_nxt  = PH_SOURCE;
                remain_nxt = {4'b0000, word_full[23:20]};
                pend_nxt   = word_full[27:24];
              end else if (word_full[27:24] != '0) begin
                phase_nxt  = PH_DEST;
                remain_nxt = {4'b0000, word_full[27:24]};
                pend_nxt   = '0;
              end else begin
                phase_nxt  = PH_HEADER;
                remain_nxt = '0;
                pend_nxt   = '0;
              end
            end
          end
          PH_CHANNEL: begin
            q_push      = 1'b1;
            q_data.kind = RK_CHANNEL;
            remain_nxt  = remain_dec;
            if (remain_dec == '0) begin
              phase_nxt = PH_HEADER;
              pend_nxt  = '0;
            end
          end
          PH_SOURCE: begin
            q_push      = 1'b1;
            q_data.kind = RK_SOURCE;
            remain_nxt  = remain_dec;
            if (remain_dec == '0) begin
              if (pend_r != '0) begin
                phase_nxt  = PH_DEST;
                remain_nxt = {4'b0000, pend_r};
                pend_nxt   = '0;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end
          end
          PH_DEST: begin
            q_push      = 1'b1;
            q_data.kind = RK_DEST;
            remain_nxt  = remain_dec;
            if (remain_dec == '0) begin
              phase_nxt = PH_HEADER;
              pend_nxt  = '0;
            end
          end
          default: begin
            phase_nxt  = PH_HEADER;
            remain_nxt = '0;
            pend_nxt   = '0;
          end
        endcase
      end

      // The last byte of a file drops any partial word and restarts the parser.
      if (in_ch.end_of_file) begin
        word_nxt   = '0;
        pos_nxt    = '0;
        phase_nxt  = PH_HEADER;
        remain_nxt = '0;
        pend_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      word_r   <= '0;
      pos_r    <= '0;
      remain_r <= '0;
      pend_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      word_r   <= word_nxt;
      pos_r    <= pos_nxt;
      remain_r <= remain_nxt;
      pend_r   <= pend_nxt;
    end
  end

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_file) |=> (phase_r == PH_HEADER && pos_r == '0))
    else $error("parser did not restart after end of file");

  a_word_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER) |-> (pos_r[2] == 1'b0 && (phase_r != PH_SKIP || pos_r == '0)))
    else $error("byte position out of range for phase");

endmodule

/* rtl/core/cssd_back.sv */
module cssd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cssd_pkg::RANK_W-1:0] own_rank,
  input  logic                      q_valid,
  input  cssd_pkg::q_entry_t        q_head,
  output logic                      q_pop,
  cssd_out_if.source                out_ch
);
  import cssd_pkg::*;

  result_t          res_r, res_nxt;
  logic             valid_r, valid_nxt;
  logic             keep;
  logic [HDR_W-1:0] w;

  assign w = q_head.word;

  always_comb begin
    res_nxt = '0;
    keep    = 1'b1;
    res_nxt.record_kind = q_head.kind;
    unique case (q_head.kind)
      RK_RESOURCE: begin
        res_nxt.thread_value      = w[9:5];
        res_nxt.notify_main       = w[14:10];
        res_nxt.notify_per_thread = w[19:15];
        res_nxt.layer             = {3'b000, w[21:20]};
      end
      RK_CHANNEL: begin
        // Channels of other ranks are consumed without a result.
        keep                  = (w[14:5] == own_rank);
        res_nxt.layer         = w[4:0];
        res_nxt.peer_rank     = w[24:15];
        res_nxt.link_protocol = w[27:25];
      end
      RK_TRANSFER: begin
        res_nxt.opcode       = w[4:0];
        res_nxt.layer        = {3'b000, w[6:5]};
        res_nxt.slice_value  = w[19:10];
        res_nxt.thread_value = w[42:38];
        res_nxt.two_bit_code = w[44:43];
        res_nxt.input_type   = w[48:45];
        res_nxt.output_type  = w[52:49];
      end
      RK_SOURCE, RK_DEST: begin
        res_nxt.two_bit_code = w[1:0];
        res_nxt.slice_value  = w[11:2];
        res_nxt.peer_rank    = w[21:12];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_pop     = q_valid && (!valid_r || out_ch.ready);
    valid_nxt = valid_r && !out_ch.ready;
    if (q_pop && keep) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && keep) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.record_kind       = res_r.record_kind;
  assign out_ch.opcode            = res_r.opcode;
  assign out_ch.thread_value      = res_r.thread_value;
  assign out_ch.notify_main       = res_r.notify_main;
  assign out_ch.notify_per_thread = res_r.notify_per_thread;
  assign out_ch.layer             = res_r.layer;
  assign out_ch.peer_rank         = res_r.peer_rank;
  assign out_ch.link_protocol     = res_r.link_protocol;
  assign out_ch.slice_value       = res_r.slice_value;
  assign out_ch.two_bit_code      = res_r.two_bit_code;
  assign out_ch.input_type        = res_r.input_type;
  assign out_ch.output_type       = res_r.output_type;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |-> !q_pop)
    else $error("pending result overwritten");

endmodule

/* rtl/core/collective_schedule_stream_decoder.sv */
// Channel    | Direction | Handshake           | Payload
// in_ch      | in        | valid/ready         | file_byte, end_of_file
// out_ch     | out       | valid/ready         | record_kind ... output_type
// APB config | in        | psel/penable, pready| own_rank at address 0
//
// One byte is accepted per cycle while the queue is not full. A completed word enters the
// two-entry queue at the edge that accepts its last byte, then moves into the output register
// once that register is empty or out_ch is ready, and from there it shows on out_ch.
// Sustained rate is one byte per cycle while the queue has room, set by the byte-wide in_ch port.
// Reset (synchronous, rst_n low) returns the parser to header phase and empties the queue.
// in_ch stalls only when the queue is full; out_ch stalls back-pressure the queue alone.
module collective_schedule_stream_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  cssd_in_if.sink                           in_ch,
  cssd_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cssd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cssd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cssd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import cssd_pkg::*;

  logic [RANK_W-1:0] own_rank_r, own_rank_nxt;
  logic              q_push, q_full, q_pop, q_valid;
  q_entry_t          q_in, q_head;

  assign pready = 1'b1;

  always_comb begin
    own_rank_nxt = own_rank_r;
    if (psel && penable && pwrite && pready && paddr[2] == REG_OWN_RANK) begin
      own_rank_nxt = pwdata[RANK_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == REG_OWN_RANK) begin
      prdata = {{(CFG_DATA_W-RANK_W){1'b0}}, own_rank_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r <= '0;
    end else begin
      own_rank_r <= own_rank_nxt;
    end
  end

  cssd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  cssd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cssd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .own_rank (own_rank_r),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
